>>> design/pdc_pkg.sv
// Shared types and constants of the PID duty controller.
// Used by every module of the block; no dependencies.
package pdc_pkg;

  localparam int unsigned GainFracBitsDef = 24;

  localparam int unsigned SampleW   = 10;
  localparam int unsigned GainW     = 32;
  localparam int unsigned GateW     = 13;
  localparam int unsigned LimitW    = 20;
  localparam int unsigned DutyW     = 8;
  localparam int unsigned ErrW      = 12;
  localparam int unsigned SumW      = 32;
  localparam int unsigned PropW     = GainW + 1 + ErrW;
  localparam int unsigned IntegW    = GainW + 1 + SumW;
  localparam int unsigned TotalW    = IntegW + 2;
  localparam int unsigned CfgAddrW  = 3;
  localparam int unsigned CfgDataW  = 32;
  localparam int unsigned InDataW   = 16;
  localparam int unsigned OutDataW  = 8;
  localparam int unsigned OutUserW  = 2;

  localparam logic [SampleW-1:0] SetpointRst = 10'd767;
  localparam logic [GainW-1:0]   PropRst     = 32'd3;
  localparam logic [GainW-1:0]   IntegRst    = 32'd411720;
  localparam logic [GainW-1:0]   DerivRst    = 32'd0;
  localparam logic [GateW-1:0]   GateRst     = 13'd5013;
  localparam logic [LimitW-1:0]  LimitRst    = 20'd4604;
  localparam logic [DutyW-1:0]   DutyMinRst  = 8'd57;
  localparam logic [DutyW-1:0]   DutyMaxRst  = 8'd122;

  typedef enum logic [CfgAddrW-1:0] {
    REG_SETPOINT = 3'd0,
    REG_PROP     = 3'd1,
    REG_INTEG    = 3'd2,
    REG_DERIV    = 3'd3,
    REG_GATE     = 3'd4,
    REG_LIMIT    = 3'd5,
    REG_DUTY_MIN = 3'd6,
    REG_DUTY_MAX = 3'd7
  } cfg_reg_t;

  typedef struct packed {
    logic [SampleW-1:0] setpoint_code;
    logic [GainW-1:0]   prop_gain;
    logic [GainW-1:0]   integ_gain;
    logic [GainW-1:0]   deriv_gain;
    logic [GateW-1:0]   error_gate;
    logic [LimitW-1:0]  integral_limit;
    logic [DutyW-1:0]   duty_min;
    logic [DutyW-1:0]   duty_max;
  } cfg_t;

  typedef struct packed {
    logic signed [ErrW-1:0] err;
    logic signed [ErrW-1:0] diff;
    logic signed [SumW-1:0] integ;
    logic                   gated;
  } err_word_t;

  typedef struct packed {
    logic signed [PropW-1:0]  prop;
    logic signed [PropW-1:0]  deriv;
    logic signed [IntegW-1:0] integ;
    logic                     gated;
  } prod_word_t;

endpackage

>>> design/pdc_cfg_regs.sv
// Configuration register bank of the PID duty controller.
// Depends on pdc_pkg.
module pdc_cfg_regs (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [pdc_pkg::CfgAddrW-1:0]    cfg_addr,
  input  logic [pdc_pkg::CfgDataW-1:0]    cfg_wdata,
  output pdc_pkg::cfg_t                   cfg
);
  import pdc_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.setpoint_code  <= SetpointRst;
      cfg.prop_gain      <= PropRst;
      cfg.integ_gain     <= IntegRst;
      cfg.deriv_gain     <= DerivRst;
      cfg.error_gate     <= GateRst;
      cfg.integral_limit <= LimitRst;
      cfg.duty_min       <= DutyMinRst;
      cfg.duty_max       <= DutyMaxRst;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_addr))
        REG_SETPOINT: cfg.setpoint_code  <= cfg_wdata[SampleW-1:0];
        REG_PROP:     cfg.prop_gain      <= cfg_wdata[GainW-1:0];
        REG_INTEG:    cfg.integ_gain     <= cfg_wdata[GainW-1:0];
        REG_DERIV:    cfg.deriv_gain     <= cfg_wdata[GainW-1:0];
        REG_GATE:     cfg.error_gate     <= cfg_wdata[GateW-1:0];
        REG_LIMIT:    cfg.integral_limit <= cfg_wdata[LimitW-1:0];
        REG_DUTY_MIN: cfg.duty_min       <= cfg_wdata[DutyW-1:0];
        REG_DUTY_MAX: cfg.duty_max       <= cfg_wdata[DutyW-1:0];
        default: ;
      endcase
    end
  end

endmodule

>>> design/pdc_error_stage.sv
// Error stage: error, gate test, clamped integral and error difference.
// Holds the integral and previous error state. Depends on pdc_pkg.
module pdc_error_stage (
  input  logic                          clk,
  input  logic                          rst,
  input  pdc_pkg::cfg_t                 cfg,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [pdc_pkg::SampleW-1:0]   sample,
  output logic                          out_valid,
  input  logic                          out_ready,
  output pdc_pkg::err_word_t            out_word
);
  import pdc_pkg::*;

  logic signed [SumW-1:0] error_sum;
  logic signed [SumW-1:0] error_sum_next;
  logic signed [ErrW-1:0] previous_error;
  logic signed [ErrW-1:0] err_raw;
  logic signed [ErrW-1:0] err_use;
  logic        [ErrW-1:0] err_mag;
  logic                   gated;
  logic signed [SumW:0]   sum_wide;
  logic signed [SumW:0]   limit_wide;
  logic signed [SumW:0]   floor_wide;
  logic signed [ErrW:0]   diff_wide;
  logic                   accept;

  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;

  always_comb begin
    err_raw    = $signed({2'b00, cfg.setpoint_code}) - $signed({2'b00, sample});
    err_mag    = err_raw[ErrW-1] ? ErrW'(-err_raw) : err_raw;
    gated      = {1'b0, err_mag} > cfg.error_gate;
    err_use    = gated ? '0 : err_raw;
    sum_wide   = {error_sum[SumW-1], error_sum}
               + {{(SumW+1-ErrW){err_use[ErrW-1]}}, err_use};
    limit_wide = $signed({{(SumW+1-LimitW){1'b0}}, cfg.integral_limit});
    floor_wide = $signed({1'b1, 1'b1, {(SumW-1){1'b0}}});
    if (gated) begin
      error_sum_next = error_sum;
    end else if (sum_wide > limit_wide) begin
      error_sum_next = limit_wide[SumW-1:0];
    end else if (sum_wide < floor_wide) begin
      error_sum_next = floor_wide[SumW-1:0];
    end else begin
      error_sum_next = sum_wide[SumW-1:0];
    end
    diff_wide = {err_use[ErrW-1], err_use} - {previous_error[ErrW-1], previous_error};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      error_sum      <= '0;
      previous_error <= '0;
      out_valid      <= 1'b0;
    end else begin
      if (accept) begin
        error_sum      <= error_sum_next;
        previous_error <= err_use;
      end
      if (in_ready) begin
        out_valid <= in_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_word.err   <= err_use;
      out_word.diff  <= diff_wide[ErrW-1:0];
      out_word.integ <= error_sum_next;
      out_word.gated <= gated;
    end
  end

endmodule

>>> design/pdc_product_stage.sv
// Product stage: the three gain products, one multiplier each.
// Depends on pdc_pkg.
module pdc_product_stage (
  input  logic                 clk,
  input  logic                 rst,
  input  pdc_pkg::cfg_t        cfg,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  pdc_pkg::err_word_t   in_word,
  output logic                 out_valid,
  input  logic                 out_ready,
  output pdc_pkg::prod_word_t  out_word
);
  import pdc_pkg::*;

  logic signed [GainW:0]    kp;
  logic signed [GainW:0]    ki;
  logic signed [GainW:0]    kd;
  logic signed [PropW-1:0]  prop_p;
  logic signed [PropW-1:0]  deriv_p;
  logic signed [IntegW-1:0] integ_p;
  logic                     accept;

  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;

  always_comb begin
    kp      = $signed({1'b0, cfg.prop_gain});
    ki      = $signed({1'b0, cfg.integ_gain});
    kd      = $signed({1'b0, cfg.deriv_gain});
    prop_p  = kp * in_word.err;
    deriv_p = kd * in_word.diff;
    integ_p = ki * in_word.integ;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_word.prop  <= prop_p;
      out_word.deriv <= deriv_p;
      out_word.integ <= integ_p;
      out_word.gated <= in_word.gated;
    end
  end

endmodule

>>> design/pdc_output_stage.sv
// Output stages: term sum, then scaling toward zero and window clamp
// into the result register. Depends on pdc_pkg.
module pdc_output_stage #(
  parameter int unsigned GAIN_FRAC_BITS = pdc_pkg::GainFracBitsDef
) (
  input  logic                          clk,
  input  logic                          rst,
  input  pdc_pkg::cfg_t                 cfg,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  pdc_pkg::prod_word_t           in_word,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [pdc_pkg::DutyW-1:0]     duty,
  output logic                          gated,
  output logic                          clamped
);
  import pdc_pkg::*;

  localparam logic [TotalW-1:0] RoundBias = (TotalW'(1) << GAIN_FRAC_BITS) - TotalW'(1);

  logic signed [TotalW-1:0] total;
  logic signed [TotalW-1:0] total_next;
  logic                     total_gated;
  logic                     total_valid;
  logic                     total_ready;
  logic                     accept;
  logic                     total_take;
  logic signed [TotalW-1:0] biased;
  logic signed [TotalW-1:0] raw;
  logic signed [TotalW-1:0] lo_wide;
  logic signed [TotalW-1:0] hi_wide;
  logic [DutyW-1:0]         duty_next;
  logic                     clamped_next;

  assign total_ready = !out_valid || out_ready;
  assign in_ready    = !total_valid || total_ready;
  assign accept      = in_valid && in_ready;
  assign total_take  = total_valid && total_ready;

  always_comb begin
    total_next = TotalW'(in_word.prop) + TotalW'(in_word.deriv) + TotalW'(in_word.integ);
  end

  always_comb begin
    biased  = total[TotalW-1] ? total + $signed(RoundBias) : total;
    raw     = biased >>> GAIN_FRAC_BITS;
    lo_wide = $signed({{(TotalW-DutyW){1'b0}}, cfg.duty_min});
    hi_wide = $signed({{(TotalW-DutyW){1'b0}}, cfg.duty_max});
    if (raw > hi_wide) begin
      duty_next    = cfg.duty_max;
      clamped_next = 1'b1;
    end else if (raw < lo_wide) begin
      duty_next    = cfg.duty_min;
      clamped_next = 1'b1;
    end else begin
      duty_next    = raw[DutyW-1:0];
      clamped_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      total_valid <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (in_ready) begin
        total_valid <= in_valid;
      end
      if (total_ready) begin
        out_valid <= total_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      total       <= total_next;
      total_gated <= in_word.gated;
    end
    if (total_take) begin
      duty    <= duty_next;
      gated   <= total_gated;
      clamped <= clamped_next;
    end
  end

endmodule

>>> design/pid_duty_controller.sv
// PID duty controller: one converter sample word in, one duty word out.
// Each word passes the error, product, term-sum and result registers in turn.
// One word per cycle sustained while m_tready stays high.
// Each stage holds its word while the next one stalls.
// Synchronous active-high rst restores register defaults, clears the
// integral and previous error, and empties the pipeline.
module pid_duty_controller #(
  parameter int unsigned GAIN_FRAC_BITS = pdc_pkg::GainFracBitsDef
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [pdc_pkg::CfgAddrW-1:0]   cfg_addr,
  input  logic [pdc_pkg::CfgDataW-1:0]   cfg_wdata,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [pdc_pkg::InDataW-1:0]    s_tdata,   // [9:0] adc_sample
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [pdc_pkg::OutDataW-1:0]   m_tdata,   // [7:0] duty
  output logic [pdc_pkg::OutUserW-1:0]   m_tuser    // [0] gated, [1] clamped
);
  import pdc_pkg::*;

  cfg_t       cfg;
  err_word_t  err_word;
  prod_word_t prod_word;
  logic       err_valid;
  logic       err_ready;
  logic       prod_valid;
  logic       prod_ready;
  logic       res_gated;
  logic       res_clamped;

  pdc_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  pdc_error_stage u_err (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .sample    (s_tdata[SampleW-1:0]),
    .out_valid (err_valid),
    .out_ready (err_ready),
    .out_word  (err_word)
  );

  pdc_product_stage u_prod (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (err_valid),
    .in_ready  (err_ready),
    .in_word   (err_word),
    .out_valid (prod_valid),
    .out_ready (prod_ready),
    .out_word  (prod_word)
  );

  pdc_output_stage #(
    .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
  ) u_out (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (prod_valid),
    .in_ready  (prod_ready),
    .in_word   (prod_word),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .duty      (m_tdata),
    .gated     (res_gated),
    .clamped   (res_clamped)
  );

  assign m_tuser = {res_clamped, res_gated};

endmodule
